// ===== rtl/hmbd_pkg.sv =====
// shared types, constants and decode functions of the memory bus decoder
package hmbd_pkg;

  localparam int ROM_BYTES = 32768;
  localparam int DMA_BYTES = 160;
  localparam int CART_AW   = $clog2(ROM_BYTES);

  // access kinds
  localparam logic [2:0] KIND_READ      = 3'd0;
  localparam logic [2:0] KIND_WRITE     = 3'd1;
  localparam logic [2:0] KIND_TIMER     = 3'd2;
  localparam logic [2:0] KIND_LOAD_CART = 3'd3;
  localparam logic [2:0] KIND_LOAD_BOOT = 3'd4;

  // special addresses
  localparam logic [15:0] ADDR_DIV      = 16'hFF04;
  localparam logic [15:0] ADDR_TIMA     = 16'hFF05;
  localparam logic [15:0] ADDR_IF       = 16'hFF0F;
  localparam logic [15:0] ADDR_DMA      = 16'hFF46;
  localparam logic [15:0] ADDR_BOOT_OFF = 16'hFF50;
  localparam logic [15:0] ADDR_IE       = 16'hFFFF;

  localparam logic [7:0] DMA_LAST = 8'(DMA_BYTES - 1);

  typedef enum logic [3:0] {
    RGN_BOOT, RGN_CART, RGN_VRAM, RGN_SRAM, RGN_WRAM,
    RGN_OAM, RGN_IO, RGN_HRAM, RGN_IE
  } region_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ACC, ST_DMA_RD, ST_DMA_WR, ST_RESP
  } state_t;

  typedef struct packed {
    logic capture;
    logic access;
    logic dma_rd;
    logic dma_wr;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_dma;
    logic dma_last;
    logic out_free;
  } ctrl_sts_t;

  // address map decode
  function automatic region_t region_of(logic [15:0] a, logic overlay);
    region_t r;
    if (!a[15]) r = (overlay && a[15:8] == 8'h00) ? RGN_BOOT : RGN_CART;
    else if (a <= 16'h9FFF) r = RGN_VRAM;
    else if (a <= 16'hBFFF) r = RGN_SRAM;
    else if (a <= 16'hFDFF) r = RGN_WRAM;
    else if (a <= 16'hFEFF) r = RGN_OAM;
    else if (a <= 16'hFF7F) r = RGN_IO;
    else if (a <= 16'hFFFE) r = RGN_HRAM;
    else r = RGN_IE;
    return r;
  endfunction

  // bits forced high on an i/o register write
  function automatic logic [7:0] io_fill(logic [6:0] i);
    logic [7:0] m;
    case (i) inside
      7'h00, 7'h20:                         m = 8'hC0;
      7'h02:                                m = 8'h7E;
      7'h03, 7'h15, 7'h1F, 7'h27, 7'h28, 7'h29,
      [7'h08:7'h0E], [7'h4C:7'h7F]:         m = 8'hFF;
      7'h07:                                m = 8'hF8;
      7'h0F:                                m = 8'hE0;
      7'h10, 7'h41:                         m = 8'h80;
      7'h1A:                                m = 8'h7F;
      7'h1C:                                m = 8'h9F;
      7'h23:                                m = 8'h3F;
      7'h26:                                m = 8'h70;
      default:                              m = 8'h00;
    endcase
    return m;
  endfunction

  // i/o register contents after reset
  function automatic logic [7:0] io_reset(logic [6:0] i);
    logic [7:0] v;
    case (i)
      7'h00:   v = 8'hC1;
      7'h41:   v = 8'h83;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/hmbd_if.sv =====
// access and result channel interfaces
interface hmbd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] address;
  logic [7:0]  data;
  modport source (output valid, kind, address, data, input ready);
  modport sink (input valid, kind, address, data, output ready);
endinterface

interface hmbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       boot_mapped;
  modport source (output valid, read_data, boot_mapped, input ready);
  modport sink (input valid, read_data, boot_mapped, output ready);
endinterface

// ===== rtl/handheld_memory_bus_decoder_core.sv =====
// top level of the handheld memory bus decoder
// One access is taken at a time. A read, write, timer write or load passes through
// capture, memory access and the result register on its way to the result, and
// the input is ready again the cycle after the result is loaded; a stalled result
// holds the block in its response state. A write of 0xFF46 runs the OAM copy:
// each of the DMA_BYTES bytes takes a registered read through the address map and
// then the object RAM write. All memories start undefined and need no clearing
// pass; the i/o registers read their reset values until first written.
module handheld_memory_bus_decoder_core import hmbd_pkg::*; (
  input logic          clk,
  input logic          rst,
  hmbd_in_if.sink      in_ch,
  hmbd_out_if.source   out_ch
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  hmbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hmbd_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_ch.kind),
    .in_address      (in_ch.address),
    .in_data         (in_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_read_data   (out_ch.read_data),
    .out_boot_mapped (out_ch.boot_mapped)
  );

endmodule

// ===== rtl/hmbd_ctrl.sv =====
// controller state machine of the memory bus decoder
module hmbd_ctrl import hmbd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.access = 1'b1;
        state_next = sts.is_dma ? ST_DMA_RD : ST_RESP;
      end
      ST_DMA_RD: begin
        cmd.dma_rd = 1'b1;
        state_next = ST_DMA_WR;
      end
      ST_DMA_WR: begin
        cmd.dma_wr = 1'b1;
        state_next = sts.dma_last ? ST_RESP : ST_DMA_RD;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/hmbd_datapath.sv =====
// memories, registers and read mux of the memory bus decoder
module hmbd_datapath import hmbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output ctrl_sts_t   sts,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic        out_boot_mapped
);

  logic [7:0] cart_mem [ROM_BYTES];
  logic [7:0] boot_mem [256];
  logic [7:0] vram_mem [8192];
  logic [7:0] sram_mem [8192];
  logic [7:0] wram_mem [8192];
  logic [7:0] oam_mem [256];
  logic [7:0] hram_mem [128];
  logic [7:0] io_mem [128];

  logic [2:0]   kind;
  logic [15:0]  addr;
  logic [7:0]   data;
  logic [7:0]   dma_index;
  logic [127:0] io_valid;
  logic [7:0]   div, tima, int_enable;
  logic         boot_overlay;

  logic [7:0] cart_q, boot_q, vram_q, sram_q, wram_q, oam_q, hram_q, io_q, alt_q;
  logic       alt_use;
  region_t    region;

  logic [15:0] ra;
  logic        rd_en;
  region_t     rrgn, wrgn;
  logic        wr, io_we, oam_we;
  logic [7:0]  alt_val, rd_byte, oam_wa, oam_wd;
  logic        alt_sel;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind <= in_kind;
      addr <= in_address;
      data <= in_data;
    end
  end

  // read address and write decode
  always_comb begin
    ra = cmd.dma_rd ? {data, dma_index} : addr;
    rd_en = cmd.dma_rd || (cmd.access && kind == KIND_READ);
    rrgn = region_of(ra, boot_overlay);
    wrgn = region_of(addr, 1'b0);
    wr = cmd.access && kind == KIND_WRITE;
    io_we = wr && wrgn == RGN_IO && addr != ADDR_DIV && addr != ADDR_TIMA &&
            addr != ADDR_DMA && (addr != ADDR_IF || int_enable != 8'h00);
    oam_we = (wr && wrgn == RGN_OAM) || cmd.dma_wr;
    oam_wa = cmd.dma_wr ? dma_index : addr[7:0];
    oam_wd = cmd.dma_wr ? rd_byte : data;
  end

  // register-backed read values
  always_comb begin
    alt_sel = 1'b0;
    alt_val = int_enable;
    if (rrgn == RGN_IE) begin
      alt_sel = 1'b1;
    end else if (rrgn == RGN_IO) begin
      if (ra[6:0] == ADDR_DIV[6:0]) begin
        alt_sel = 1'b1;
        alt_val = div;
      end else if (ra[6:0] == ADDR_TIMA[6:0]) begin
        alt_sel = 1'b1;
        alt_val = tima;
      end else if (!io_valid[ra[6:0]]) begin
        alt_sel = 1'b1;
        alt_val = io_reset(ra[6:0]);
      end
    end
  end

  // memory arrays
  always_ff @(posedge clk) begin
    if (cmd.access && kind == KIND_LOAD_CART) cart_mem[addr[CART_AW-1:0]] <= data;
    if (rd_en) cart_q <= cart_mem[ra[CART_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.access && kind == KIND_LOAD_BOOT) boot_mem[addr[7:0]] <= data;
    if (rd_en) boot_q <= boot_mem[ra[7:0]];
  end

  always_ff @(posedge clk) begin
    if (wr && wrgn == RGN_VRAM) vram_mem[addr[12:0]] <= data;
    if (rd_en) vram_q <= vram_mem[ra[12:0]];
  end

  always_ff @(posedge clk) begin
    if (wr && wrgn == RGN_SRAM) sram_mem[addr[12:0]] <= data;
    if (rd_en) sram_q <= sram_mem[ra[12:0]];
  end

  always_ff @(posedge clk) begin
    if (wr && wrgn == RGN_WRAM) wram_mem[addr[12:0]] <= data;
    if (rd_en) wram_q <= wram_mem[ra[12:0]];
  end

  always_ff @(posedge clk) begin
    if (oam_we) oam_mem[oam_wa] <= oam_wd;
    if (rd_en) oam_q <= oam_mem[ra[7:0]];
  end

  always_ff @(posedge clk) begin
    if (wr && wrgn == RGN_HRAM) hram_mem[addr[6:0]] <= data;
    if (rd_en) hram_q <= hram_mem[ra[6:0]];
  end

  always_ff @(posedge clk) begin
    if (io_we) io_mem[addr[6:0]] <= data | io_fill(addr[6:0]);
    if (rd_en) io_q <= io_mem[ra[6:0]];
  end

  // read side registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      region  <= rrgn;
      alt_use <= alt_sel;
      alt_q   <= alt_val;
    end
  end

  // read byte select
  always_comb begin
    case (region)
      RGN_BOOT: rd_byte = boot_q;
      RGN_CART: rd_byte = cart_q;
      RGN_VRAM: rd_byte = vram_q;
      RGN_SRAM: rd_byte = sram_q;
      RGN_WRAM: rd_byte = wram_q;
      RGN_OAM:  rd_byte = oam_q;
      RGN_IO:   rd_byte = io_q;
      RGN_HRAM: rd_byte = hram_q;
      default:  rd_byte = 8'h00;
    endcase
    if (alt_use) rd_byte = alt_q;
  end

  // control registers, timers and copy counter
  always_ff @(posedge clk) begin
    if (rst) begin
      io_valid     <= '0;
      div          <= 8'h00;
      tima         <= 8'h00;
      int_enable   <= 8'h00;
      boot_overlay <= 1'b1;
      dma_index    <= 8'h00;
    end else begin
      if (io_we) io_valid[addr[6:0]] <= 1'b1;
      if (wr && addr == ADDR_DIV) begin
        div  <= 8'h00;
        tima <= 8'h00;
      end
      if (wr && addr == ADDR_TIMA) tima <= data;
      if (cmd.access && kind == KIND_TIMER && addr == ADDR_DIV) div <= data;
      if (cmd.access && kind == KIND_TIMER && addr == ADDR_TIMA) tima <= data;
      if (wr && addr == ADDR_IE) int_enable <= data;
      if (wr && addr == ADDR_BOOT_OFF && data == 8'h01) boot_overlay <= 1'b0;
      if (cmd.dma_wr) dma_index <= (dma_index == DMA_LAST) ? 8'h00 : dma_index + 8'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_read_data   <= (kind == KIND_READ) ? rd_byte : 8'h00;
      out_boot_mapped <= boot_overlay;
    end
  end

  // status to controller
  assign sts.is_dma   = kind == KIND_WRITE && addr == ADDR_DMA;
  assign sts.dma_last = dma_index == DMA_LAST;
  assign sts.out_free = !out_valid || out_ready;

endmodule

// ===== rtl/hmbd_checker.sv =====
// port-level checks of the memory bus decoder and their binding
module hmbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data,
  input logic       boot_mapped
);

  logic seen_unmapped;

  // remember a result that showed the boot rom unmapped
  always_ff @(posedge clk) begin
    if (rst) seen_unmapped <= 1'b0;
    else if (out_valid && !boot_mapped) seen_unmapped <= 1'b1;
  end

  // one access at a time
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // no fresh result rises early after a transfer
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ##1 !(out_valid && !$past(out_valid)))
    else $error("result appeared too early");

  // boot rom never comes back
  a_boot_stays_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_unmapped |-> !boot_mapped)
    else $error("boot rom mapped again");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(boot_mapped))
    else $error("stalled result changed");

endmodule

bind handheld_memory_bus_decoder_core hmbd_checker u_hmbd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .read_data   (out_ch.read_data),
  .boot_mapped (out_ch.boot_mapped)
);

// ===== dv/tb_hmbd_if.sv =====
// timing constants of the testbench stimulus and end drain
package tb_hmbd_consts_pkg;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int END_DRAIN_CYCLES = 2 * 160 + 20;
endpackage

// ===== dv/tb_handheld_memory_bus_decoder_core.sv =====
// testbench of the handheld memory bus decoder: directed and random accesses
module tb_handheld_memory_bus_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;
  import hmbd_pkg::*;
  import tb_hmbd_consts_pkg::*;

  typedef struct packed {
    logic [7:0] read_data;
    logic       boot_mapped;
  } bus_result_t;

  logic clk;
  logic rst;
  hmbd_in_if  acc_ch ();
  hmbd_out_if res_ch ();

  handheld_memory_bus_decoder_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (acc_ch.sink),
    .out_ch (res_ch.source)
  );

  // predictor state
  logic [7:0] cart_mem [ROM_BYTES];
  logic [7:0] boot_mem [256];
  logic [7:0] vram_mem [8192];
  logic [7:0] sram_mem [8192];
  logic [7:0] wram_mem [8192];
  logic [7:0] oam_mem  [256];
  logic [7:0] hram_mem [128];
  logic [7:0] io_mem   [128];
  logic [7:0] ie_reg;
  logic       overlay;
  // which bytes were written, so that reads stay inside the contract
  bit cart_ok [ROM_BYTES];
  bit boot_ok [256];
  bit vram_ok [8192];
  bit sram_ok [8192];
  bit wram_ok [8192];
  bit oam_ok  [256];
  bit hram_ok [128];

  bus_result_t expected_results [$];
  int error_count;
  bit hold_off;
  bit stall_enable;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // limit
  initial begin
    #2000000;
    $display("tb_handheld_memory_bus_decoder_core: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  function automatic bit is_readable(input logic [15:0] a);
    if (a <= 16'h7FFF) begin
      if (overlay && a < 16'h100) return boot_ok[a[7:0]];
      return cart_ok[a % ROM_BYTES];
    end
    if (a <= 16'h9FFF) return vram_ok[a - 16'h8000];
    if (a <= 16'hBFFF) return sram_ok[a - 16'hA000];
    if (a <= 16'hDFFF) return wram_ok[a - 16'hC000];
    if (a <= 16'hFDFF) return wram_ok[a - 16'hE000];
    if (a <= 16'hFEFF) return oam_ok[a - 16'hFE00];
    if (a >= 16'hFF80 && a <= 16'hFFFE) return hram_ok[a - 16'hFF80];
    return 1'b1;
  endfunction

  function automatic logic [7:0] map_read(input logic [15:0] a);
    if (a <= 16'h7FFF) begin
      if (overlay && a < 16'h100) return boot_mem[a[7:0]];
      return cart_mem[a % ROM_BYTES];
    end
    if (a <= 16'h9FFF) return vram_mem[a - 16'h8000];
    if (a <= 16'hBFFF) return sram_mem[a - 16'hA000];
    if (a <= 16'hDFFF) return wram_mem[a - 16'hC000];
    if (a <= 16'hFDFF) return wram_mem[a - 16'hE000];
    if (a <= 16'hFEFF) return oam_mem[a - 16'hFE00];
    if (a <= 16'hFF7F) return io_mem[a[6:0]];
    if (a <= 16'hFFFE) return hram_mem[a - 16'hFF80];
    return ie_reg;
  endfunction

  function automatic bit dma_source_ok(input logic [7:0] page);
    logic [15:0] a;
    for (int i = 0; i < DMA_BYTES; i++) begin
      a = {page, 8'h00} + 16'(i);
      if (!is_readable(a)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] fill_bits(input logic [15:0] a);
    case (a)
      16'hFF00, 16'hFF20: return 8'hC0;
      16'hFF02: return 8'h7E;
      16'hFF03, 16'hFF15, 16'hFF1F, 16'hFF27, 16'hFF28, 16'hFF29: return 8'hFF;
      16'hFF07: return 8'hF8;
      16'hFF10, 16'hFF41: return 8'h80;
      16'hFF1A: return 8'h7F;
      16'hFF1C: return 8'h9F;
      16'hFF23: return 8'h3F;
      16'hFF26: return 8'h70;
      default: ;
    endcase
    if (a >= 16'hFF08 && a <= 16'hFF0E) return 8'hFF;
    if (a >= 16'hFF4C && a <= 16'hFF7F) return 8'hFF;
    return 8'h00;
  endfunction

  // predict one access and update the model state
  function automatic bus_result_t predict_access(input logic [2:0] kind,
                                                 input logic [15:0] a,
                                                 input logic [7:0] d);
    bus_result_t r;
    logic [15:0] src;
    r.read_data = 8'h00;
    case (kind)
      KIND_READ: r.read_data = map_read(a);
      KIND_WRITE: begin
        if (a >= 16'h8000 && a <= 16'h9FFF) begin
          vram_mem[a - 16'h8000] = d; vram_ok[a - 16'h8000] = 1;
        end else if (a >= 16'hA000 && a <= 16'hBFFF) begin
          sram_mem[a - 16'hA000] = d; sram_ok[a - 16'hA000] = 1;
        end else if (a >= 16'hC000 && a <= 16'hDFFF) begin
          wram_mem[a - 16'hC000] = d; wram_ok[a - 16'hC000] = 1;
        end else if (a >= 16'hE000 && a <= 16'hFDFF) begin
          wram_mem[a - 16'hE000] = d; wram_ok[a - 16'hE000] = 1;
        end else if (a >= 16'hFE00 && a <= 16'hFEFF) begin
          oam_mem[a - 16'hFE00] = d; oam_ok[a - 16'hFE00] = 1;
        end else if (a >= 16'hFF00 && a <= 16'hFF7F) begin
          if (a == ADDR_DIV) begin
            io_mem[7'h04] = 8'h00; io_mem[7'h05] = 8'h00;
          end else if (a == ADDR_IF) begin
            if (ie_reg != 8'h00) io_mem[7'h0F] = d | 8'hE0;
          end else if (a == ADDR_DMA) begin
            for (int i = 0; i < DMA_BYTES; i++) begin
              src = {d, 8'h00} + 16'(i);
              oam_mem[i] = map_read(src);
              oam_ok[i] = 1;
            end
          end else begin
            io_mem[a[6:0]] = d | fill_bits(a);
          end
        end else if (a >= 16'hFF80 && a <= 16'hFFFE) begin
          hram_mem[a - 16'hFF80] = d; hram_ok[a - 16'hFF80] = 1;
        end else if (a == ADDR_IE) begin
          ie_reg = d;
        end
        if (a == ADDR_BOOT_OFF && d == 8'h01) overlay = 1'b0;
      end
      KIND_TIMER: if (a == ADDR_DIV || a == ADDR_TIMA) io_mem[a[6:0]] = d;
      KIND_LOAD_CART: begin
        cart_mem[a % ROM_BYTES] = d; cart_ok[a % ROM_BYTES] = 1;
      end
      KIND_LOAD_BOOT: begin
        boot_mem[a[7:0]] = d; boot_ok[a[7:0]] = 1;
      end
      default: ;
    endcase
    r.boot_mapped = overlay;
    return r;
  endfunction

  // send one access; the prediction is made at the transfer edge
  // the gap before valid rises is never empty, so valid drops before the next item starts
  task automatic send_access(input logic [2:0] kind, input logic [15:0] a,
                             input logic [7:0] d);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
    if ($urandom_range(0, 3) == 0) gap = 1;
    repeat (gap) @(posedge clk);
    acc_ch.valid   <= 1'b1;
    acc_ch.kind    <= kind;
    acc_ch.address <= a;
    acc_ch.data    <= d;
    do @(posedge clk); while (!acc_ch.ready);
    expected_results.push_back(predict_access(kind, a, d));
    acc_ch.valid <= 1'b0;
  endtask

  // result side stalls
  initial begin
    res_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) res_ch.ready <= 1'b0;
      else if (stall_enable && $urandom_range(0, 3) == 0) res_ch.ready <= 1'b0;
      else res_ch.ready <= 1'b1;
    end
  end

  // result checker
  initial begin
    bus_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", res_ch.read_data, 0);
        end else begin
          want = expected_results.pop_front();
          if (res_ch.read_data !== want.read_data)
            report_mismatch("read_data", res_ch.read_data, want.read_data);
          if (res_ch.boot_mapped !== want.boot_mapped)
            report_mismatch("boot_mapped", res_ch.boot_mapped, want.boot_mapped);
        end
      end
    end
  end

  function automatic logic [15:0] pick_readable_addr();
    logic [15:0] a;
    for (int t = 0; t < 20; t++) begin
      a = 16'($urandom());
      if (is_readable(a)) return a;
    end
    return 16'hFF00 + 16'($urandom_range(0, 127));
  endfunction

  // directed: loads, reads of the boot, cartridge, i/o and work ram regions, masks and side effects
  task automatic test_directed();
    send_access(KIND_LOAD_BOOT, 16'h0000, 8'hA5);
    send_access(KIND_LOAD_BOOT, 16'hFFFF, 8'hFF);
    send_access(KIND_LOAD_CART, 16'h0000, 8'h3C);
    send_access(KIND_LOAD_CART, 16'hFFFF, 8'h00);
    send_access(KIND_READ, 16'h0000, 8'h00);
    send_access(KIND_READ, 16'h00FF, 8'hFF);
    send_access(KIND_READ, 16'h7FFF, 8'h00);
    send_access(KIND_WRITE, 16'h0000, 8'h55);
    send_access(KIND_READ, 16'hFF00, 8'h00);
    send_access(KIND_WRITE, 16'hFF0F, 8'h01);
    send_access(KIND_WRITE, 16'hFFFF, 8'h1F);
    send_access(KIND_WRITE, 16'hFF0F, 8'h01);
    send_access(KIND_READ, 16'hFF0F, 8'h00);
    send_access(KIND_TIMER, 16'hFF04, 8'h77);
    send_access(KIND_TIMER, 16'hFF05, 8'h88);
    send_access(KIND_TIMER, 16'hFF06, 8'h99);
    send_access(KIND_WRITE, 16'hFF04, 8'h12);
    send_access(KIND_READ, 16'hFF05, 8'h00);
    send_access(KIND_WRITE, 16'hFF7F, 8'h00);
    send_access(KIND_READ, 16'hFF7F, 8'h00);
    send_access(3'd7, 16'hFFFF, 8'hFF);
    send_access(KIND_WRITE, 16'hE000, 8'hC3);
    send_access(KIND_READ, 16'hC000, 8'h00);
  endtask

  // oam copy from work ram under a long result hold-off
  task automatic test_dma_pressure();
    for (int i = 0; i < DMA_BYTES; i++)
      send_access(KIND_WRITE, 16'hC100 + 16'(i), 8'($urandom()));
    fork
      begin
        hold_off = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_access(KIND_WRITE, ADDR_DMA, 8'hC1);
        for (int i = 0; i < 6; i++) send_access(KIND_READ, 16'hFE00 + 16'(i * 31), 8'h00);
      end
    join
  endtask

  // random mix, mostly writes and reads of written bytes
  task automatic test_random(input int n);
    logic [2:0] k;
    logic [15:0] a;
    logic [7:0] d;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      d = 8'($urandom());
      if (sel < 35) begin
        k = KIND_READ; a = pick_readable_addr();
      end else if (sel < 70) begin
        k = KIND_WRITE; a = 16'($urandom());
        if (a == ADDR_DMA && !dma_source_ok(d)) a = 16'hFF47;
        if (a == ADDR_BOOT_OFF && $urandom_range(0, 3) != 0) d = 8'h00;
      end else if (sel < 78) begin
        k = KIND_TIMER;
        a = ($urandom_range(0, 1)) ? 16'hFF04 + 16'($urandom_range(0, 1)) : 16'($urandom());
      end else if (sel < 88) begin
        k = KIND_LOAD_CART; a = 16'($urandom());
      end else if (sel < 95) begin
        k = KIND_LOAD_BOOT; a = 16'($urandom());
      end else if (sel < 97) begin
        k = 3'($urandom_range(5, 7)); a = 16'($urandom());
      end else begin
        k = KIND_WRITE; a = ADDR_DMA;
        d = 8'hFE;
        if (!dma_source_ok(d)) d = 8'hC1;
      end
      send_access(k, a, d);
    end
  endtask

  // boot rom unmap near the end
  task automatic test_boot_unmap();
    send_access(KIND_WRITE, ADDR_BOOT_OFF, 8'h01);
    send_access(KIND_READ, 16'h0000, 8'h00);
    send_access(KIND_READ, ADDR_BOOT_OFF, 8'h00);
    test_random(100);
  endtask

  initial begin
    int wait_cycles;
    rst = 1'b1;
    acc_ch.valid = 1'b0;
    acc_ch.kind = KIND_READ;
    acc_ch.address = 16'h0000;
    acc_ch.data = 8'h00;
    hold_off = 1'b0;
    stall_enable = 1'b0;
    error_count = 0;
    overlay = 1'b1;
    ie_reg = 8'h00;
    for (int i = 0; i < 128; i++) io_mem[i] = 8'h00;
    io_mem[7'h00] = 8'hC1;
    io_mem[7'h41] = 8'h83;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    stall_enable = 1'b1;
    test_dma_pressure();
    test_random(1600);
    test_boot_unmap();
    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (END_DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0)
      $display("tb_handheld_memory_bus_decoder_core: done, clean");
    else
      $display("tb_handheld_memory_bus_decoder_core: done, errors");
    $finish;
  end
endmodule
